// File: src/pgt_pkg.sv
package pgt_pkg;

    // Default token length limit and queue depth
    localparam int MAX_TOKEN_LEN_DEF = 255;
    localparam int QUEUE_DEPTH_DEF   = 4;

    // Token kinds
    localparam logic [3:0] KIND_LBRACKET = 4'd0;
    localparam logic [3:0] KIND_RBRACKET = 4'd1;
    localparam logic [3:0] KIND_LPAREN   = 4'd2;
    localparam logic [3:0] KIND_RPAREN   = 4'd3;
    localparam logic [3:0] KIND_LANGLE   = 4'd4;
    localparam logic [3:0] KIND_RANGLE   = 4'd5;
    localparam logic [3:0] KIND_DOT      = 4'd6;
    localparam logic [3:0] KIND_STRING   = 4'd7;
    localparam logic [3:0] KIND_SYMBOL   = 4'd8;
    localparam logic [3:0] KIND_INTEGER  = 4'd9;
    localparam logic [3:0] KIND_EOF      = 4'd10;
    localparam logic [3:0] KIND_UNKNOWN  = 4'd11;

    // Characters with a role of their own
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_HASH       = 8'h23;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_SEMICOLON  = 8'h3B;
    localparam logic [7:0] CH_LBRACKET   = 8'h5B;
    localparam logic [7:0] CH_RBRACKET   = 8'h5D;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_LANGLE     = 8'h3C;
    localparam logic [7:0] CH_RANGLE     = 8'h3E;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;

    // One result word
    typedef struct packed {
        logic       is_token_end;
        logic [7:0] value_char;
        logic [3:0] token_kind;
        logic [7:0] token_length;
        logic       truncated;
        logic       unterminated;
        logic       last_of_run;
    } result_t;

    // Queue entry: the results of one input word, one or two of them
    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } entry_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_sym_char(input logic [7:0] c);
        return is_alnum(c) || (c == CH_UNDERSCORE) || (c == CH_PLUS) ||
               (c == CH_HASH) || (c == CH_EQUAL) || (c == CH_COLON) ||
               (c == CH_MINUS);
    endfunction

    function automatic result_t value_word(input logic [7:0] c);
        result_t r;
        r = '0;
        r.value_char = c;
        return r;
    endfunction

    function automatic result_t end_word(input logic [3:0] kind, input logic [7:0] len,
                                         input logic trunc, input logic unterm,
                                         input logic [7:0] c);
        result_t r;
        r = '0;
        r.is_token_end = 1'b1;
        r.value_char   = c;
        r.token_kind   = kind;
        r.token_length = len;
        r.truncated    = trunc;
        r.unterminated = unterm;
        return r;
    endfunction

endpackage

// File: src/pgt_if.sv
interface pgt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface pgt_out_if;
    logic       valid;
    logic       ready;
    logic       is_token_end;
    logic [7:0] value_char;
    logic [3:0] token_kind;
    logic [7:0] token_length;
    logic       truncated;
    logic       unterminated;
    logic       last_of_run;

    modport source (output valid, output is_token_end, output value_char,
                    output token_kind, output token_length, output truncated,
                    output unterminated, output last_of_run, input ready);
    modport sink   (input valid, input is_token_end, input value_char,
                    input token_kind, input token_length, input truncated,
                    input unterminated, input last_of_run, output ready);
endinterface

// File: src/pgt_front.sv
module pgt_front #(
    parameter int MAX_TOKEN_LEN = pgt_pkg::MAX_TOKEN_LEN_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    pgt_in_if.sink          in_ch,
    input  logic            full,
    output logic            push,
    output pgt_pkg::entry_t push_entry
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_COMMENT,
        MODE_STRING,
        MODE_SYMBOL
    } mode_t;

    localparam logic [7:0] MaxLen = 8'(MAX_TOKEN_LEN);

    mode_t      mode_reg, mode_next;
    logic [7:0] count_reg, count_next;
    logic       digits_reg, digits_next;
    logic       ovf_reg, ovf_next;

    logic            accept;
    logic [7:0]      c;
    logic            eoi;
    logic            can_keep;
    logic [1:0]      n;
    pgt_pkg::result_t r0, r1, sym_end, eof_word;

    // Outcome of a byte seen between tokens
    logic             bt_n;
    pgt_pkg::result_t bt_res;
    mode_t            bt_mode;
    logic [7:0]       bt_count;
    logic             bt_digits;

    assign in_ch.ready = !full;
    assign accept      = in_ch.valid && !full;
    assign c           = in_ch.in_byte;
    assign eoi         = in_ch.end_of_input;
    assign can_keep    = count_reg < MaxLen;
    assign eof_word    = pgt_pkg::end_word(pgt_pkg::KIND_EOF, 8'd0, 1'b0, 1'b0, 8'd0);
    assign sym_end     = pgt_pkg::end_word(digits_reg ? pgt_pkg::KIND_INTEGER
                                                      : pgt_pkg::KIND_SYMBOL,
                                           count_reg, ovf_reg, 1'b0, 8'd0);

    // Classify a byte as the start of a token
    always_comb
    begin
        bt_n      = 1'b0;
        bt_res    = '0;
        bt_mode   = MODE_IDLE;
        bt_count  = 8'd0;
        bt_digits = 1'b1;
        case (c)
            pgt_pkg::CH_LBRACKET:
            begin
                bt_n   = 1'b1;
                bt_res = pgt_pkg::end_word(pgt_pkg::KIND_LBRACKET, 8'd0, 1'b0, 1'b0, 8'd0);
            end
            pgt_pkg::CH_RBRACKET:
            begin
                bt_n   = 1'b1;
                bt_res = pgt_pkg::end_word(pgt_pkg::KIND_RBRACKET, 8'd0, 1'b0, 1'b0, 8'd0);
            end
            pgt_pkg::CH_LPAREN:
            begin
                bt_n   = 1'b1;
                bt_res = pgt_pkg::end_word(pgt_pkg::KIND_LPAREN, 8'd0, 1'b0, 1'b0, 8'd0);
            end
            pgt_pkg::CH_RPAREN:
            begin
                bt_n   = 1'b1;
                bt_res = pgt_pkg::end_word(pgt_pkg::KIND_RPAREN, 8'd0, 1'b0, 1'b0, 8'd0);
            end
            pgt_pkg::CH_LANGLE:
            begin
                bt_n   = 1'b1;
                bt_res = pgt_pkg::end_word(pgt_pkg::KIND_LANGLE, 8'd0, 1'b0, 1'b0, 8'd0);
            end
            pgt_pkg::CH_RANGLE:
            begin
                bt_n   = 1'b1;
                bt_res = pgt_pkg::end_word(pgt_pkg::KIND_RANGLE, 8'd0, 1'b0, 1'b0, 8'd0);
            end
            pgt_pkg::CH_DOT:
            begin
                bt_n   = 1'b1;
                bt_res = pgt_pkg::end_word(pgt_pkg::KIND_DOT, 8'd0, 1'b0, 1'b0, 8'd0);
            end
            pgt_pkg::CH_SEMICOLON:
            begin
                bt_mode = MODE_COMMENT;
            end
            pgt_pkg::CH_QUOTE:
            begin
                bt_mode = MODE_STRING;
            end
            default:
            begin
                if (pgt_pkg::is_space(c))
                begin
                    bt_n = 1'b0;
                end
                else if (pgt_pkg::is_alnum(c))
                begin
                    bt_mode   = MODE_SYMBOL;
                    bt_digits = pgt_pkg::is_digit(c);
                    bt_n      = 1'b1;
                    bt_res    = pgt_pkg::value_word(c);
                    bt_count  = 8'd1;
                end
                else
                begin
                    bt_n   = 1'b1;
                    bt_res = pgt_pkg::end_word(pgt_pkg::KIND_UNKNOWN, 8'd1, 1'b0, 1'b0, c);
                end
            end
        endcase
    end

    // Advance the lexer by one word
    always_comb
    begin
        mode_next   = mode_reg;
        count_next  = count_reg;
        digits_next = digits_reg;
        ovf_next    = ovf_reg;
        n           = 2'd0;
        r0          = '0;
        r1          = '0;
        case (mode_reg)
            MODE_COMMENT:
            begin
                if (eoi)
                begin
                    r0        = eof_word;
                    n         = 2'd1;
                    mode_next = MODE_IDLE;
                    count_next  = 8'd0;
                    digits_next = 1'b1;
                    ovf_next    = 1'b0;
                end
                else if ((c == pgt_pkg::CH_LF) || (c == pgt_pkg::CH_CR))
                begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_STRING:
            begin
                if (eoi || (c == pgt_pkg::CH_QUOTE))
                begin
                    r0 = pgt_pkg::end_word(pgt_pkg::KIND_STRING, count_reg, ovf_reg,
                                           eoi, 8'd0);
                    r1 = eof_word;
                    n  = eoi ? 2'd2 : 2'd1;
                    mode_next   = MODE_IDLE;
                    count_next  = 8'd0;
                    digits_next = 1'b1;
                    ovf_next    = 1'b0;
                end
                else if (can_keep)
                begin
                    r0         = pgt_pkg::value_word(c);
                    n          = 2'd1;
                    count_next = count_reg + 8'd1;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            MODE_SYMBOL:
            begin
                if (eoi)
                begin
                    r0 = sym_end;
                    r1 = eof_word;
                    n  = 2'd2;
                    mode_next   = MODE_IDLE;
                    count_next  = 8'd0;
                    digits_next = 1'b1;
                    ovf_next    = 1'b0;
                end
                else if (pgt_pkg::is_sym_char(c))
                begin
                    digits_next = digits_reg & pgt_pkg::is_digit(c);
                    if (can_keep)
                    begin
                        r0         = pgt_pkg::value_word(c);
                        n          = 2'd1;
                        count_next = count_reg + 8'd1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                else
                begin
                    // close the symbol, then treat the byte as between tokens
                    r0          = sym_end;
                    r1          = bt_res;
                    n           = bt_n ? 2'd2 : 2'd1;
                    mode_next   = bt_mode;
                    count_next  = bt_count;
                    digits_next = bt_digits;
                    ovf_next    = 1'b0;
                end
            end
            default:
            begin
                if (eoi)
                begin
                    r0 = eof_word;
                    n  = 2'd1;
                    mode_next   = MODE_IDLE;
                    count_next  = 8'd0;
                    digits_next = 1'b1;
                    ovf_next    = 1'b0;
                end
                else
                begin
                    r0          = bt_res;
                    n           = {1'b0, bt_n};
                    mode_next   = bt_mode;
                    count_next  = bt_count;
                    digits_next = bt_digits;
                    ovf_next    = 1'b0;
                end
            end
        endcase

        // mark the last result of this word
        if (n == 2'd1)
        begin
            r0.last_of_run = 1'b1;
        end
        if (n == 2'd2)
        begin
            r1.last_of_run = 1'b1;
        end
    end

    assign push              = accept && (n != 2'd0);
    assign push_entry.two    = (n == 2'd2);
    assign push_entry.first  = r0;
    assign push_entry.second = r1;

    // Hold lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            count_reg  <= 8'd0;
            digits_reg <= 1'b1;
            ovf_reg    <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            count_reg  <= count_next;
            digits_reg <= digits_next;
            ovf_reg    <= ovf_next;
        end
    end

endmodule

// File: src/pgt_fifo.sv
module pgt_fifo #(
    parameter int DEPTH = pgt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pgt_pkg::entry_t wdata,
    input  logic            pop,
    output pgt_pkg::entry_t head,
    output logic            empty,
    output logic            full
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastIdx = PtrW'(DEPTH - 1);

    pgt_pkg::entry_t mem [DEPTH];

    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CntW'(DEPTH));
    assign head  = mem[rd_ptr_reg];

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LastIdx) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LastIdx) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: src/pgt_back.sv
module pgt_back (
    input  logic            clk,
    input  logic            rst_n,
    input  pgt_pkg::entry_t head,
    input  logic            empty,
    output logic            pop,
    pgt_out_if.source       out_ch
);

    logic             half_reg, half_next;
    logic             ovalid_reg, ovalid_next;
    pgt_pkg::result_t odata_reg, odata_next;
    logic             load;

    // Load a result whenever the output register is free
    assign load = !empty && (!ovalid_reg || out_ch.ready);
    assign pop  = load && (!head.two || half_reg);

    always_comb
    begin
        half_next   = half_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        if (load)
        begin
            half_next   = head.two && !half_reg;
            ovalid_next = 1'b1;
            odata_next  = half_reg ? head.second : head.first;
        end
        else if (out_ch.ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            half_reg   <= half_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        odata_reg <= odata_next;
    end

    // Drive the result channel
    assign out_ch.valid        = ovalid_reg;
    assign out_ch.is_token_end = odata_reg.is_token_end;
    assign out_ch.value_char   = odata_reg.value_char;
    assign out_ch.token_kind   = odata_reg.token_kind;
    assign out_ch.token_length = odata_reg.token_length;
    assign out_ch.truncated    = odata_reg.truncated;
    assign out_ch.unterminated = odata_reg.unterminated;
    assign out_ch.last_of_run  = odata_reg.last_of_run;

endmodule

// File: src/pgn_tokenizer_core.sv
// Results of an accepted input word enter the queue, then the free output register.
// Throughput: one input word per cycle while the queue is not full; the output register
// sends one result word per cycle while the receiver is ready, so a word that yields a
// token end and an eof (or a symbol end and a new token) sends its two result words one
// after the other; a queue of four entries by default absorbs that.
// Reset (rst_n low, asynchronous): lexer returns to idle, queue empties,
// output valid drops.
module pgn_tokenizer_core #(
    parameter int MAX_TOKEN_LEN = pgt_pkg::MAX_TOKEN_LEN_DEF,
    parameter int QUEUE_DEPTH   = pgt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    pgt_in_if.sink    in_ch,
    pgt_out_if.source out_ch
);

    logic            push, pop, empty, full;
    pgt_pkg::entry_t push_entry, head;

    pgt_front #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .full       (full),
        .push       (push),
        .push_entry (push_entry)
    );

    pgt_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_entry),
        .pop   (pop),
        .head  (head),
        .empty (empty),
        .full  (full)
    );

    pgt_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .empty  (empty),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule

// File: src/pgt_checker.sv
module pgt_props (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       is_token_end,
    input logic [3:0] token_kind,
    input logic [7:0] token_length,
    input logic       truncated,
    input logic       unterminated,
    input logic       last_of_run
);

    // Hold a stalled result
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // Value words carry no token information
    a_value_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_token_end |->
            token_kind == 4'd0 && token_length == 8'd0 && !truncated && !unterminated)
        else $error("value word carries token fields");

    // An unterminated string is always followed by eof in the same run
    a_unterm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && unterminated |->
            is_token_end && token_kind == pgt_pkg::KIND_STRING && !last_of_run)
        else $error("unterminated flag on wrong word");

    // Eof closes its run and is empty
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_token_end && token_kind == pgt_pkg::KIND_EOF |->
            last_of_run && token_length == 8'd0)
        else $error("eof token malformed");

endmodule

bind pgn_tokenizer_core pgt_props u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .is_token_end (out_ch.is_token_end),
    .token_kind   (out_ch.token_kind),
    .token_length (out_ch.token_length),
    .truncated    (out_ch.truncated),
    .unterminated (out_ch.unterminated),
    .last_of_run  (out_ch.last_of_run)
);

// File: test/pgt_checker.sv
`timescale 1ns / 100ps

module pgt_checker #(
    parameter int MAX_LEN = pgt_pkg::MAX_TOKEN_LEN_DEF
) (
    input  logic clk,
    input  logic rst_n,
    pgt_in_if    in_mon,
    pgt_out_if   out_mon,
    output int   fail_count,
    output int   pending,
    output int   words_in,
    output int   words_out,
    output int   ends_seen,
    output int   clipped_seen,
    output int   open_seen
);

    typedef enum logic [1:0] {LX_IDLE, LX_COMMENT, LX_STRING, LX_SYMBOL} lex_state_t;

    localparam int PRINT_CAP = 40;

    // Lexer copy kept in step with the block
    lex_state_t lx_state;
    logic [7:0] kept_len;
    logic       all_digits;
    logic       clipped;

    pgt_pkg::result_t step_words[$];
    pgt_pkg::result_t token_stream_q[$];
    pgt_pkg::result_t got;
    pgt_pkg::result_t want;
    string   bad;
    int      fails;
    int      n_in;
    int      n_out;
    int      n_ends;
    int      n_clipped;
    int      n_open;

    function automatic bit digit_ch(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic bit letter_ch(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic bit blank_ch(input logic [7:0] c);
        return c inside {pgt_pkg::CH_SPACE, [pgt_pkg::CH_TAB:pgt_pkg::CH_CR]};
    endfunction

    function automatic bit tail_ch(input logic [7:0] c);
        return digit_ch(c) || letter_ch(c) ||
               (c inside {pgt_pkg::CH_UNDERSCORE, pgt_pkg::CH_PLUS, pgt_pkg::CH_HASH,
                          pgt_pkg::CH_EQUAL, pgt_pkg::CH_COLON, pgt_pkg::CH_MINUS});
    endfunction

    function automatic pgt_pkg::result_t close_word(input logic [3:0] kind,
                                                    input logic [7:0] len,
                                                    input logic trunc, input logic unterm,
                                                    input logic [7:0] c);
        pgt_pkg::result_t w;
        w = '0;
        w.is_token_end = 1'b1;
        w.value_char   = c;
        w.token_kind   = kind;
        w.token_length = len;
        w.truncated    = trunc;
        w.unterminated = unterm;
        return w;
    endfunction

    function automatic string word_text(input pgt_pkg::result_t w);
        return $sformatf("end=%0d ch=%02h kind=%0d len=%0d trunc=%0d unterm=%0d last=%0d",
                         w.is_token_end, w.value_char, w.token_kind, w.token_length,
                         w.truncated, w.unterminated, w.last_of_run);
    endfunction

    task automatic report_fault(input string what, input pgt_pkg::result_t seen,
                                input pgt_pkg::result_t due);
        if (fails < PRINT_CAP)
            $display("%0t MISMATCH %s | got %s | want %s", $realtime, what,
                     word_text(seen), word_text(due));
        fails++;
    endtask

    task automatic clear_lexer();
        lx_state   = LX_IDLE;
        kept_len   = 8'd0;
        all_digits = 1'b1;
        clipped    = 1'b0;
    endtask

    // Keep a value character while under the limit, else drop it and flag
    task automatic hold_char(input logic [7:0] c);
        pgt_pkg::result_t w;
        if (kept_len < MAX_LEN)
        begin
            w = '0;
            w.value_char = c;
            step_words.push_back(w);
            kept_len = kept_len + 8'd1;
        end
        else
            clipped = 1'b1;
    endtask

    task automatic close_symbol();
        step_words.push_back(close_word(all_digits ? pgt_pkg::KIND_INTEGER
                                                   : pgt_pkg::KIND_SYMBOL,
                                        kept_len, clipped, 1'b0, 8'd0));
    endtask

    task automatic push_punct(input logic [3:0] kind);
        step_words.push_back(close_word(kind, 8'd0, 1'b0, 1'b0, 8'd0));
    endtask

    // Handle a byte seen between tokens
    task automatic open_token(input logic [7:0] c);
        clear_lexer();
        case (c)
            pgt_pkg::CH_LBRACKET: push_punct(pgt_pkg::KIND_LBRACKET);
            pgt_pkg::CH_RBRACKET: push_punct(pgt_pkg::KIND_RBRACKET);
            pgt_pkg::CH_LPAREN:   push_punct(pgt_pkg::KIND_LPAREN);
            pgt_pkg::CH_RPAREN:   push_punct(pgt_pkg::KIND_RPAREN);
            pgt_pkg::CH_LANGLE:   push_punct(pgt_pkg::KIND_LANGLE);
            pgt_pkg::CH_RANGLE:   push_punct(pgt_pkg::KIND_RANGLE);
            pgt_pkg::CH_DOT:      push_punct(pgt_pkg::KIND_DOT);
            default:
            begin
                if (c == pgt_pkg::CH_SEMICOLON)
                    lx_state = LX_COMMENT;
                else if (c == pgt_pkg::CH_QUOTE)
                    lx_state = LX_STRING;
                else if (letter_ch(c) || digit_ch(c))
                begin
                    lx_state   = LX_SYMBOL;
                    all_digits = digit_ch(c);
                    hold_char(c);
                end
                else if (!blank_ch(c))
                    step_words.push_back(close_word(pgt_pkg::KIND_UNKNOWN, 8'd1, 1'b0,
                                                    1'b0, c));
            end
        endcase
    endtask

    // Work out the result words of one accepted input word
    task automatic lex_byte(input logic [7:0] c, input logic eoi);
        step_words.delete();
        case (lx_state)
            LX_COMMENT:
            begin
                if (eoi)
                begin
                    push_punct(pgt_pkg::KIND_EOF);
                    clear_lexer();
                end
                else if (c == pgt_pkg::CH_LF || c == pgt_pkg::CH_CR)
                    lx_state = LX_IDLE;
            end
            LX_STRING:
            begin
                if (eoi)
                begin
                    step_words.push_back(close_word(pgt_pkg::KIND_STRING, kept_len, clipped,
                                                    1'b1, 8'd0));
                    push_punct(pgt_pkg::KIND_EOF);
                    clear_lexer();
                end
                else if (c == pgt_pkg::CH_QUOTE)
                begin
                    step_words.push_back(close_word(pgt_pkg::KIND_STRING, kept_len, clipped,
                                                    1'b0, 8'd0));
                    clear_lexer();
                end
                else
                    hold_char(c);
            end
            LX_SYMBOL:
            begin
                if (eoi)
                begin
                    close_symbol();
                    push_punct(pgt_pkg::KIND_EOF);
                    clear_lexer();
                end
                else if (tail_ch(c))
                begin
                    // dropped characters still take part in the digits-only test
                    all_digits = all_digits & digit_ch(c);
                    hold_char(c);
                end
                else
                begin
                    close_symbol();
                    open_token(c);
                end
            end
            default:
            begin
                if (eoi)
                begin
                    push_punct(pgt_pkg::KIND_EOF);
                    clear_lexer();
                end
                else
                    open_token(c);
            end
        endcase
        if (step_words.size() != 0)
            step_words[step_words.size() - 1].last_of_run = 1'b1;
        foreach (step_words[i])
            token_stream_q.push_back(step_words[i]);
    endtask

    // Predict on accepted input words, compare accepted result words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_stream_q.delete();
            clear_lexer();
            fails     = 0;
            n_in      = 0;
            n_out     = 0;
            n_ends    = 0;
            n_clipped = 0;
            n_open    = 0;
        end
        else
        begin
            if (in_mon.valid && in_mon.ready)
            begin
                lex_byte(in_mon.in_byte, in_mon.end_of_input);
                n_in++;
            end
            if (out_mon.valid && out_mon.ready)
            begin
                got.is_token_end = out_mon.is_token_end;
                got.value_char   = out_mon.value_char;
                got.token_kind   = out_mon.token_kind;
                got.token_length = out_mon.token_length;
                got.truncated    = out_mon.truncated;
                got.unterminated = out_mon.unterminated;
                got.last_of_run  = out_mon.last_of_run;
                n_out++;
                if (token_stream_q.size() == 0)
                    report_fault("result word with nothing expected", got, '0);
                else
                begin
                    want = token_stream_q.pop_front();
                    n_ends    += want.is_token_end;
                    n_clipped += want.truncated;
                    n_open    += want.unterminated;
                    bad = "";
                    if (got.is_token_end !== want.is_token_end)
                        bad = {bad, " is_token_end"};
                    if (got.value_char !== want.value_char)
                        bad = {bad, " value_char"};
                    if (got.token_kind !== want.token_kind)
                        bad = {bad, " token_kind"};
                    if (got.token_length !== want.token_length)
                        bad = {bad, " token_length"};
                    if (got.truncated !== want.truncated)
                        bad = {bad, " truncated"};
                    if (got.unterminated !== want.unterminated)
                        bad = {bad, " unterminated"};
                    if (got.last_of_run !== want.last_of_run)
                        bad = {bad, " last_of_run"};
                    if (bad != "")
                        report_fault({"field", bad}, got, want);
                end
            end
        end
        fail_count   <= fails;
        pending      <= token_stream_q.size();
        words_in     <= n_in;
        words_out    <= n_out;
        ends_seen    <= n_ends;
        clipped_seen <= n_clipped;
        open_seen    <= n_open;
    end

endmodule

// File: test/pgn_tokenizer_core_test.sv
`timescale 1ns / 100ps

module pgn_tokenizer_core_test;

    localparam int TOKEN_LIMIT = pgt_pkg::MAX_TOKEN_LEN_DEF;
    localparam int WORD_TARGET = 1500;
    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    pgt_in_if  in_ch ();
    pgt_out_if out_ch ();

    int fail_count;
    int pending;
    int words_in;
    int words_out;
    int ends_seen;
    int clipped_seen;
    int open_seen;

    int useful_words = 0;
    int token_no     = 0;
    int hold_left;
    int stall;
    bit tx_steady    = 1'b0;
    bit rx_steady    = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    pgn_tokenizer_core #(
        .MAX_TOKEN_LEN(TOKEN_LIMIT)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    pgt_checker #(
        .MAX_LEN(TOKEN_LIMIT)
    ) lex_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_mon       (in_ch),
        .out_mon      (out_ch),
        .fail_count   (fail_count),
        .pending      (pending),
        .words_in     (words_in),
        .words_out    (words_out),
        .ends_seen    (ends_seen),
        .clipped_seen (clipped_seen),
        .open_seen    (open_seen)
    );

    // Mostly no gap, sometimes a short one, rarely a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 8);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] digit_char();
        return 8'(8'h30 + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] alnum_char();
        int r;
        r = $urandom_range(0, 61);
        if (r < 10)
            return 8'(8'h30 + r);
        else if (r < 36)
            return 8'(8'h41 + r - 10);
        else
            return 8'(8'h61 + r - 36);
    endfunction

    function automatic logic [7:0] tail_char();
        case ($urandom_range(0, 11))
            0:       return pgt_pkg::CH_UNDERSCORE;
            1:       return pgt_pkg::CH_PLUS;
            2:       return pgt_pkg::CH_HASH;
            3:       return pgt_pkg::CH_EQUAL;
            4:       return pgt_pkg::CH_COLON;
            5:       return pgt_pkg::CH_MINUS;
            default: return alnum_char();
        endcase
    endfunction

    // Body byte of a string or comment, never one of the two closing bytes
    function automatic logic [7:0] body_char(input logic [7:0] stop_a, input logic [7:0] stop_b);
        logic [7:0] c;
        c = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(32, 126));
        if (c == stop_a || c == stop_b)
            c = 8'h61;
        return c;
    endfunction

    // Offer one word, after an optional gap, and hold it until accepted
    task automatic send_word(input logic [7:0] c, input logic eoi);
        int gap;
        gap = tx_steady ? 0 : gap_len();
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.in_byte      <= c;
        in_ch.end_of_input <= eoi;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        useful_words++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b0);
    endtask

    task automatic send_eoi();
        send_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Hold the sender until every expected result word has come out
    task automatic drain_pause();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Emit one random piece of game text
    task automatic emit_token();
        int         pick;
        int         len;
        bit         digits_only;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        token_no++;
        if (token_no inside {10, 60, 120})
        begin
            // long tokens: symbol exactly at the limit, integer and string past it
            len = (token_no == 10) ? TOKEN_LIMIT :
                  (token_no == 60) ? TOKEN_LIMIT + 1 : TOKEN_LIMIT + 2;
            if (token_no == 120)
                send_word(pgt_pkg::CH_QUOTE, 1'b0);
            for (int i = 0; i < len; i++)
            begin
                if (token_no == 60)
                    send_word(digit_char(), 1'b0);
                else if (token_no == 10 && i == 0)
                    send_word(8'(8'h41 + $urandom_range(0, 25)), 1'b0);
                else if (token_no == 10)
                    send_word(tail_char(), 1'b0);
                else
                    send_word(body_char(pgt_pkg::CH_QUOTE, pgt_pkg::CH_QUOTE), 1'b0);
            end
            send_word((token_no == 120) ? pgt_pkg::CH_QUOTE : pgt_pkg::CH_SPACE, 1'b0);
        end
        else if (pick < 12)
        begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++)
            begin
                case ($urandom_range(0, 5))
                    0:       c = pgt_pkg::CH_TAB;
                    1:       c = pgt_pkg::CH_LF;
                    2:       c = CH_VT;
                    3:       c = CH_FF;
                    4:       c = pgt_pkg::CH_CR;
                    default: c = pgt_pkg::CH_SPACE;
                endcase
                send_word(c, 1'b0);
            end
        end
        else if (pick < 22)
        begin
            case ($urandom_range(0, 6))
                0:       c = pgt_pkg::CH_LBRACKET;
                1:       c = pgt_pkg::CH_RBRACKET;
                2:       c = pgt_pkg::CH_LPAREN;
                3:       c = pgt_pkg::CH_RPAREN;
                4:       c = pgt_pkg::CH_LANGLE;
                5:       c = pgt_pkg::CH_RANGLE;
                default: c = pgt_pkg::CH_DOT;
            endcase
            send_word(c, 1'b0);
        end
        else if (pick < 44)
        begin
            // symbol or integer, ended by a blank or by whatever comes next
            digits_only = ($urandom_range(0, 4) < 2);
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
            begin
                if (digits_only)
                    send_word(digit_char(), 1'b0);
                else if (i == 0)
                    send_word(alnum_char(), 1'b0);
                else
                    send_word(tail_char(), 1'b0);
            end
            if ($urandom_range(0, 1) == 0)
                send_word(pgt_pkg::CH_SPACE, 1'b0);
        end
        else if (pick < 52)
        begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++)
                send_word(digit_char(), 1'b0);
            len = ($urandom_range(0, 2) == 0) ? 3 : 1;
            for (int i = 0; i < len; i++)
                send_word(pgt_pkg::CH_DOT, 1'b0);
            send_word(pgt_pkg::CH_SPACE, 1'b0);
        end
        else if (pick < 62)
        begin
            send_word(pgt_pkg::CH_QUOTE, 1'b0);
            len = $urandom_range(0, 12);
            for (int i = 0; i < len; i++)
                send_word(body_char(pgt_pkg::CH_QUOTE, pgt_pkg::CH_QUOTE), 1'b0);
            send_word(pgt_pkg::CH_QUOTE, 1'b0);
        end
        else if (pick < 68)
        begin
            send_word(pgt_pkg::CH_SEMICOLON, 1'b0);
            len = $urandom_range(0, 12);
            for (int i = 0; i < len; i++)
                send_word(body_char(pgt_pkg::CH_LF, pgt_pkg::CH_CR), 1'b0);
            send_word(($urandom_range(0, 1) == 0) ? pgt_pkg::CH_LF : pgt_pkg::CH_CR, 1'b0);
        end
        else if (pick < 78)
        begin
            // tag pair such as [Event "x"]
            send_word(pgt_pkg::CH_LBRACKET, 1'b0);
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                send_word(alnum_char(), 1'b0);
            send_word(pgt_pkg::CH_SPACE, 1'b0);
            send_word(pgt_pkg::CH_QUOTE, 1'b0);
            len = $urandom_range(0, 10);
            for (int i = 0; i < len; i++)
                send_word(body_char(pgt_pkg::CH_QUOTE, pgt_pkg::CH_QUOTE), 1'b0);
            send_word(pgt_pkg::CH_QUOTE, 1'b0);
            send_word(pgt_pkg::CH_RBRACKET, 1'b0);
            send_word(pgt_pkg::CH_LF, 1'b0);
        end
        else if (pick < 88)
            send_word(8'($urandom_range(0, 255)), 1'b0);
        else if (pick < 93)
            send_eoi();
        else
        begin
            // open symbol, string or comment cut off by end of input
            case ($urandom_range(0, 2))
                0:       send_word(alnum_char(), 1'b0);
                1:       send_word(pgt_pkg::CH_QUOTE, 1'b0);
                default: send_word(pgt_pkg::CH_SEMICOLON, 1'b0);
            endcase
            len = $urandom_range(0, 4);
            for (int i = 0; i < len; i++)
                send_word(tail_char(), 1'b0);
            send_eoi();
        end
    endtask

    // Receiver: stall at random, with steady stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            hold_left    <= 0;
        end
        else if (hold_left != 0)
        begin
            out_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (rx_steady)
            out_ch.ready <= 1'b1;
        else
        begin
            stall = gap_len();
            out_ch.ready <= (stall == 0);
            hold_left    <= (stall == 0) ? 0 : stall - 1;
        end
    end

    initial
    begin
        #30_000_000;
        $display("timeout with %0d result words still expected", pending);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int n;
        in_ch.valid        = 1'b0;
        in_ch.in_byte      = 8'd0;
        in_ch.end_of_input = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: punctuation, empty string, symbol ended by punctuation,
        // integer ended by end of input, unknown bytes, comments, open string
        send_text("[]()<>.");
        send_text("\"\"");
        send_text("Nf3(");
        send_text("09");
        send_eoi();
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(pgt_pkg::CH_UNDERSCORE, 1'b0);
        send_text(";x");
        send_word(pgt_pkg::CH_CR, 1'b0);
        send_text(";");
        send_eoi();
        send_text("\"z");
        send_eoi();
        send_eoi();
        drain_pause();

        // Random text, with steady and bursty phases and a few full drains
        while (useful_words < WORD_TARGET)
        begin
            if (token_no % 40 == 0)
            begin
                tx_steady = ($urandom_range(0, 3) == 0);
                rx_steady <= ($urandom_range(0, 3) == 0);
            end
            if (token_no % 150 == 75)
                drain_pause();
            emit_token();
        end

        in_ch.valid <= 1'b0;
        @(posedge clk);
        for (n = 0; n < 5000 && pending != 0; n++)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d input words, %0d result words, %0d token ends",
                 words_in, words_out, ends_seen);
        $display("tokens cut at the length limit: %0d, strings open at end of input: %0d",
                 clipped_seen, open_seen);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
        begin
            $display("%0d mismatches, %0d result words never came", fail_count, pending);
            $display("simulation failed");
        end
        $finish;
    end

endmodule
